>>> design/canonical_huffman_escape_decoder_assert.svh
// assertion macros for the canonical huffman escape decoder
// used by canonical_huffman_escape_decoder.sv; expects clk and rst in scope
`ifndef CANONICAL_HUFFMAN_ESCAPE_DECODER_ASSERT_SVH
`define CANONICAL_HUFFMAN_ESCAPE_DECODER_ASSERT_SVH

// same-cycle implication
`define CHED_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define CHED_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/ched_pkg.sv
// shared types and constants for the canonical huffman escape decoder
// no dependencies
package ched_pkg;

  localparam int BURST_DEF = 16;
  localparam int MAX_CODE_LEN_DEF = 16;
  localparam int MAX_RESULTS = 16;

  localparam logic [15:0] SKIP_FLAG = 16'h0100;
  localparam logic [15:0] TYPE_DELTA1 = 16'h32fb;
  localparam logic [15:0] TYPE_DELTA2 = 16'h34fb;
  localparam logic [23:0] SIZE_MAX24 = 24'hffffff;
  localparam logic [5:0] ZERO_LIMIT = 6'd32;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_MALFORMED = 2'd1;
  localparam logic [1:0] ST_PENDING = 2'd2;
  localparam logic [1:0] ST_AFTER_END = 2'd3;

  typedef struct packed {
    logic       cmd;
    logic [7:0] data_byte;
  } in_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        last;
    logic        end_of_stream;
    logic        pending;
    logic [1:0]  status;
    logic [23:0] decoded_size;
  } out_t;

  typedef enum logic [11:0] {
    PH_TYPE     = 12'b000000000001,
    PH_SKIP     = 12'b000000000010,
    PH_SIZE     = 12'b000000000100,
    PH_ESC      = 12'b000000001000,
    PH_COUNTS   = 12'b000000010000,
    PH_SYMS     = 12'b000000100000,
    PH_DECODE   = 12'b000001000000,
    PH_ESC_NUM  = 12'b000010000000,
    PH_ESC_FLAG = 12'b000100000000,
    PH_ESC_BYTE = 12'b001000000000,
    PH_END      = 12'b010000000000,
    PH_ERROR    = 12'b100000000000
  } phase_t;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001,
    S_STEP = 7'b0000010,
    S_MOD  = 7'b0000100,
    S_WALK = 7'b0001000,
    S_LOOK = 7'b0010000,
    S_FIN  = 7'b0100000,
    S_SEND = 7'b1000000
  } ctl_t;

endpackage

>>> design/canonical_huffman_escape_decoder.sv
// Canonical huffman decoder with escape runs, one stream per reset. After reset the
// used-symbol map is cleared one entry per cycle, so no request is taken until the
// clear pass is done. Each request is processed by a sequencer that takes one stream
// bit or one run byte per cycle, except where it pauses: a body code hit adds a
// symbol table read, and each leapfrog symbol adds a bit-serial modulo and then a
// walk over the used-symbol map that steps over up to 256 symbols. A request ends
// with a finish state, and then its results are sent in order, each held until
// out_ready takes it, at most min(BURST,16) results per request.
// in_ready is high only while idle. Results of one request all carry the
// end_of_stream and pending flags as they stand when the request completes.
// depends on ched_pkg.sv and canonical_huffman_escape_decoder_assert.svh
`include "canonical_huffman_escape_decoder_assert.svh"

module canonical_huffman_escape_decoder #(
  parameter int BURST = ched_pkg::BURST_DEF,
  parameter int MAX_CODE_LEN = ched_pkg::MAX_CODE_LEN_DEF
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  ched_pkg::in_t in_data,
  output logic          out_valid,
  input  logic          out_ready,
  output ched_pkg::out_t out_data
);
  import ched_pkg::*;

  localparam int LIM = (BURST < MAX_RESULTS) ? BURST : MAX_RESULTS;
  localparam int NW = $clog2(LIM + 1);
  localparam int IW = $clog2(LIM);

  ctl_t ctl;
  phase_t phase;

  logic [7:0] win;
  logic [3:0] bcnt;
  logic [15:0] stream_type;
  logic [23:0] size_reg;
  logic [7:0] escape_symbol;
  logic [8:0] count_per_length [16];
  logic [16:0] limit_per_length [16];
  logic [15:0] offset_per_length [16];
  logic [7:0] symbol_table [256];
  logic symbol_used [256];
  logic [7:0] tbl_rdata;
  logic used_rdata;
  logic [8:0] clr_cnt;
  logic [7:0] next_symbol;
  logic [8:0] symbol_total;
  logic [31:0] run_left;
  logic [7:0] previous_raw, sum_first, sum_second;
  logic [23:0] bytes_emitted;

  logic [23:0] fld_acc;
  logic [4:0] fld_left;
  logic num_stage;
  logic [5:0] num_zeros, num_width, num_left;
  logic [31:0] num_acc;
  logic [4:0] len_now, longest, code_len;
  logic [16:0] space_used;
  logic [8:0] sym_index;
  logic [15:0] code_acc;

  logic [31:0] div_num;
  logic [9:0] div_rem;
  logic [4:0] div_cnt;
  logic [8:0] walk_d;
  logic [7:0] walk_s;

  logic [NW-1:0] n, k;
  logic [7:0] rbuf_byte [LIM];
  logic [1:0] rbuf_st [LIM];
  logic fin_eos, fin_pend;

  // bit fetch
  logic b, consume, run_emit;
  assign b = win[7];
  assign run_emit = (phase == PH_DECODE) && (run_left != 32'd0);
  assign consume = (ctl == S_STEP) && (n < NW'(LIM)) && !run_emit && (bcnt != 4'd0);

  // fixed fields
  logic [23:0] fld_acc_n;
  logic fld_done;
  assign fld_acc_n = {fld_acc[22:0], b};
  assign fld_done = (fld_left <= 5'd1);

  // variable-length numbers
  logic num_phase, num_fin, num_fault;
  logic [31:0] num_acc_n, num_val;
  assign num_phase = (phase == PH_COUNTS) || (phase == PH_SYMS) || (phase == PH_ESC_NUM);
  assign num_acc_n = {num_acc[30:0], b};
  assign num_fin = num_stage && (num_left == 6'd1);
  assign num_fault = !num_stage && !b && ((num_zeros + 6'd1) >= ZERO_LIMIT);
  assign num_val = num_acc_n + ((num_width < 6'd32) ? (32'd1 << num_width[4:0]) : 32'd0)
                   - 32'd4;

  // code count checks
  logic [17:0] cnt_first, cnt_full;
  logic [33:0] cnt_top;
  logic cnt_bad, cnt_done;
  assign cnt_first = {space_used, 1'b0};
  assign cnt_full = 18'd1 << len_now;
  assign cnt_top = 34'(cnt_first) + 34'(num_val);
  assign cnt_bad = (cnt_top > 34'(cnt_full)) ||
                   ((33'(symbol_total) + 33'(num_val)) > 33'd256);
  assign cnt_done = (num_val != 32'd0) && (cnt_top == 34'(cnt_full));

  // body code search
  logic [15:0] dec_acc;
  logic [4:0] dec_len;
  logic [3:0] dec_i;
  logic dec_hit;
  logic [7:0] raddr;
  assign dec_acc = {code_acc[14:0], b};
  assign dec_len = code_len + 5'd1;
  assign dec_i = code_len[3:0];
  assign dec_hit = (count_per_length[dec_i] != 9'd0) &&
                   ({1'b0, dec_acc} < limit_per_length[dec_i]);
  assign raddr = 8'(dec_acc - offset_per_length[dec_i]);

  logic fault;
  assign fault = consume && ((num_phase && num_fault) ||
                 ((phase == PH_COUNTS) && num_fin &&
                  (cnt_bad || (!cnt_done && (len_now >= 5'(MAX_CODE_LEN))))) ||
                 ((phase == PH_DECODE) && !dec_hit && (dec_len >= longest)));

  // modulo and walk; walk_s is the candidate whose used bit is in used_rdata
  logic [9:0] divisor, div_step;
  logic [7:0] walk_s1, used_raddr;
  logic walk_take;
  assign divisor = 10'd256 - {1'b0, sym_index};
  assign div_step = ({div_rem[8:0], div_num[31]} >= divisor) ?
                    ({div_rem[8:0], div_num[31]} - divisor) : {div_rem[8:0], div_num[31]};
  assign walk_s1 = walk_s + 8'd1;
  assign used_raddr = (ctl == S_WALK) ? walk_s1 : (next_symbol + 8'd1);
  assign walk_take = (ctl == S_WALK) && !used_rdata && (walk_d == 9'd1);

  // byte delivery with undelta
  logic [7:0] dl_raw, dl_val, dl_s1, dl_s2;
  logic dl_active;
  always_comb begin
    if (ctl == S_LOOK) dl_raw = tbl_rdata;
    else if (run_emit) dl_raw = previous_raw;
    else dl_raw = fld_acc_n[7:0];
  end
  assign dl_active = bytes_emitted < size_reg;
  assign dl_s1 = sum_first + dl_raw;
  assign dl_s2 = sum_second + dl_s1;
  always_comb begin
    if (dl_active && (stream_type == TYPE_DELTA1)) dl_val = dl_s1;
    else if (dl_active && (stream_type == TYPE_DELTA2)) dl_val = dl_s2;
    else dl_val = dl_raw;
  end

  logic do_deliver;
  assign do_deliver = ((ctl == S_STEP) && (n < NW'(LIM)) && run_emit) ||
                      ((ctl == S_LOOK) && (tbl_rdata != escape_symbol)) ||
                      (consume && !fault && (phase == PH_ESC_BYTE) && fld_done);

  logic [IW-1:0] n_idx;
  assign n_idx = n[IW-1:0];

  // symbol memory
  always_ff @(posedge clk) begin
    if (walk_take) symbol_table[sym_index[7:0]] <= walk_s;
    tbl_rdata <= symbol_table[raddr];
  end

  // used-symbol map, cleared by a pass after reset
  always_ff @(posedge clk) begin
    if (!clr_cnt[8]) begin
      symbol_used[clr_cnt[7:0]] <= 1'b0;
    end else if (walk_take) begin
      symbol_used[walk_s] <= 1'b1;
    end
    used_rdata <= symbol_used[used_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl <= S_IDLE;
      phase <= PH_TYPE;
      clr_cnt <= '0;
      win <= '0;
      bcnt <= '0;
      stream_type <= '0;
      size_reg <= '0;
      escape_symbol <= '0;
      for (int i = 0; i < 16; i++) begin
        count_per_length[i] <= '0;
        limit_per_length[i] <= '0;
        offset_per_length[i] <= '0;
      end
      next_symbol <= 8'hff;
      symbol_total <= '0;
      run_left <= '0;
      previous_raw <= '0;
      sum_first <= '0;
      sum_second <= '0;
      bytes_emitted <= '0;
      fld_acc <= '0;
      fld_left <= 5'd16;
      num_stage <= 1'b0;
      num_zeros <= '0;
      num_width <= '0;
      num_left <= '0;
      num_acc <= '0;
      len_now <= 5'd1;
      space_used <= '0;
      longest <= '0;
      sym_index <= '0;
      code_acc <= '0;
      code_len <= '0;
      n <= '0;
      k <= '0;
      fin_eos <= 1'b0;
      fin_pend <= 1'b0;
    end else begin
      if (!clr_cnt[8]) clr_cnt <= clr_cnt + 9'd1;
      if (do_deliver) begin
        rbuf_byte[n_idx] <= dl_val;
        rbuf_st[n_idx] <= ST_OK;
        n <= n + NW'(1);
        previous_raw <= dl_raw;
        if (dl_active && ((stream_type == TYPE_DELTA1) || (stream_type == TYPE_DELTA2)))
          sum_first <= dl_s1;
        if (dl_active && (stream_type == TYPE_DELTA2)) sum_second <= dl_s2;
        if (bytes_emitted < SIZE_MAX24) bytes_emitted <= bytes_emitted + 24'd1;
      end
      unique case (ctl)
        S_IDLE: begin
          n <= '0;
          if (in_valid && clr_cnt[8]) begin
            ctl <= S_FIN;
            if (phase == PH_END) begin
              if (!in_data.cmd) begin
                rbuf_byte[0] <= '0;
                rbuf_st[0] <= ST_AFTER_END;
                n <= NW'(1);
              end
            end else if (phase == PH_ERROR) begin
              rbuf_byte[0] <= '0;
              rbuf_st[0] <= ST_MALFORMED;
              n <= NW'(1);
            end else if (!in_data.cmd) begin
              if ((run_left != 32'd0) || (bcnt != 4'd0)) begin
                rbuf_byte[0] <= '0;
                rbuf_st[0] <= ST_PENDING;
                n <= NW'(1);
              end else begin
                win <= in_data.data_byte;
                bcnt <= 4'd8;
                ctl <= S_STEP;
              end
            end else begin
              ctl <= S_STEP;
            end
          end
        end
        S_STEP: begin
          if (n >= NW'(LIM)) begin
            ctl <= S_FIN;
          end else if (run_emit) begin
            run_left <= run_left - 32'd1;
          end else if (bcnt == 4'd0) begin
            ctl <= S_FIN;
          end else if (fault) begin
            win <= '0;
            bcnt <= '0;
            run_left <= '0;
            phase <= PH_ERROR;
            rbuf_byte[n_idx] <= '0;
            rbuf_st[n_idx] <= ST_MALFORMED;
            n <= n + NW'(1);
            ctl <= S_FIN;
          end else begin
            win <= {win[6:0], 1'b0};
            bcnt <= bcnt - 4'd1;
            if (num_phase) begin
              if (!num_stage) begin
                if (!b) begin
                  num_zeros <= num_zeros + 6'd1;
                end else begin
                  num_width <= num_zeros + 6'd2;
                  num_left <= num_zeros + 6'd2;
                  num_acc <= '0;
                  num_stage <= 1'b1;
                end
              end else begin
                num_acc <= num_acc_n;
                num_left <= num_left - 6'd1;
                if (num_fin) begin
                  num_stage <= 1'b0;
                  num_zeros <= '0;
                end
              end
            end
            if (!num_phase) begin
              fld_acc <= fld_acc_n;
              if (fld_left != 5'd0) fld_left <= fld_left - 5'd1;
            end
            unique case (phase)
              PH_TYPE: begin
                if (fld_done) begin
                  stream_type <= fld_acc_n[15:0] & ~SKIP_FLAG;
                  phase <= ((fld_acc_n[15:0] & SKIP_FLAG) != 16'd0) ? PH_SKIP : PH_SIZE;
                  fld_acc <= '0;
                  fld_left <= 5'd24;
                end
              end
              PH_SKIP: begin
                if (fld_done) begin
                  phase <= PH_SIZE;
                  fld_acc <= '0;
                  fld_left <= 5'd24;
                end
              end
              PH_SIZE: begin
                if (fld_done) begin
                  size_reg <= fld_acc_n;
                  phase <= PH_ESC;
                  fld_acc <= '0;
                  fld_left <= 5'd8;
                end
              end
              PH_ESC: begin
                if (fld_done) begin
                  escape_symbol <= fld_acc_n[7:0];
                  phase <= PH_COUNTS;
                  len_now <= 5'd1;
                  space_used <= '0;
                  symbol_total <= '0;
                end
              end
              PH_COUNTS: begin
                if (num_fin) begin
                  count_per_length[len_now[3:0] - 4'd1] <= num_val[8:0];
                  limit_per_length[len_now[3:0] - 4'd1] <= cnt_top[16:0];
                  offset_per_length[len_now[3:0] - 4'd1] <=
                    16'(cnt_first - 18'(symbol_total));
                  symbol_total <= symbol_total + num_val[8:0];
                  space_used <= cnt_top[16:0];
                  if (cnt_done) begin
                    longest <= len_now;
                    phase <= PH_SYMS;
                    sym_index <= '0;
                  end else begin
                    len_now <= len_now + 5'd1;
                  end
                end
              end
              PH_SYMS: begin
                if (num_fin) begin
                  div_num <= num_val;
                  div_rem <= '0;
                  div_cnt <= '0;
                  ctl <= S_MOD;
                end
              end
              PH_DECODE: begin
                if (dec_hit) begin
                  code_acc <= '0;
                  code_len <= '0;
                  ctl <= S_LOOK;
                end else begin
                  code_acc <= dec_acc;
                  code_len <= dec_len;
                end
              end
              PH_ESC_NUM: begin
                if (num_fin) begin
                  if (num_val != 32'd0) begin
                    run_left <= num_val;
                    phase <= PH_DECODE;
                  end else begin
                    phase <= PH_ESC_FLAG;
                  end
                end
              end
              PH_ESC_FLAG: begin
                if (b) begin
                  phase <= PH_END;
                  win <= '0;
                  bcnt <= '0;
                  if (n == NW'(0)) begin
                    rbuf_byte[0] <= '0;
                    rbuf_st[0] <= ST_OK;
                    n <= NW'(1);
                  end
                  ctl <= S_FIN;
                end else begin
                  phase <= PH_ESC_BYTE;
                  fld_acc <= '0;
                  fld_left <= 5'd8;
                end
              end
              PH_ESC_BYTE: begin
                if (fld_done) phase <= PH_DECODE;
              end
              default: begin
              end
            endcase
          end
        end
        S_MOD: begin
          div_rem <= div_step;
          div_num <= {div_num[30:0], 1'b0};
          div_cnt <= div_cnt + 5'd1;
          if (div_cnt == 5'd31) begin
            walk_d <= div_step[8:0] + 9'd1;
            walk_s <= next_symbol + 8'd1;
            ctl <= S_WALK;
          end
        end
        S_WALK: begin
          walk_s <= walk_s1;
          if (!used_rdata) begin
            if (walk_d == 9'd1) begin
              next_symbol <= walk_s;
              sym_index <= sym_index + 9'd1;
              if ((sym_index + 9'd1) >= symbol_total) begin
                phase <= PH_DECODE;
                code_acc <= '0;
                code_len <= '0;
              end
              ctl <= S_STEP;
            end else begin
              walk_d <= walk_d - 9'd1;
            end
          end
        end
        S_LOOK: begin
          if (tbl_rdata == escape_symbol) phase <= PH_ESC_NUM;
          ctl <= S_STEP;
        end
        S_FIN: begin
          fin_eos <= (phase == PH_END);
          fin_pend <= (phase != PH_END) && (phase != PH_ERROR) &&
                      ((run_left != 32'd0) || (bcnt != 4'd0));
          k <= '0;
          ctl <= (n == NW'(0)) ? S_IDLE : S_SEND;
        end
        S_SEND: begin
          if (out_ready) begin
            k <= k + NW'(1);
            if (k == (n - NW'(1))) ctl <= S_IDLE;
          end
        end
        default: begin
          ctl <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready = (ctl == S_IDLE) && clr_cnt[8];
  assign out_valid = (ctl == S_SEND);
  always_comb begin
    out_data.out_byte = rbuf_byte[k[IW-1:0]];
    out_data.last = (k == (n - NW'(1)));
    out_data.end_of_stream = fin_eos;
    out_data.pending = fin_pend;
    out_data.status = rbuf_st[k[IW-1:0]];
    out_data.decoded_size = size_reg;
  end

  `CHED_ASSERT_NOW(a_no_overlap, out_valid, !in_ready, "result shown while request taken")
  `CHED_ASSERT_NOW(a_count_bound, 1'b1, n <= NW'(LIM), "result count beyond burst")
  `CHED_ASSERT_NOW(a_walk_phase, (ctl == S_WALK) || (ctl == S_MOD), phase == PH_SYMS,
                   "symbol walk outside symbol list")
  `CHED_ASSERT_NXT(a_accept_leaves, in_valid && in_ready, (ctl == S_FIN) || (ctl == S_STEP),
                   "accepted request not started")

endmodule

>>> tb/testbench.sv
// testbench for canonical_huffman_escape_decoder: one randomly built stream per run
// (header, code tables, literals, runs, explicit bytes, end or fault) checked by a predictor
// depends on ched_pkg.sv and canonical_huffman_escape_decoder.sv
`timescale 1ns / 100ps

module testbench;
  import ched_pkg::*;

  localparam int BURST = BURST_DEF;
  localparam int CODE_LEN = MAX_CODE_LEN_DEF;
  localparam int LIMIT = 2000000;
  localparam int HOLD_CYCLES = 300;

  typedef enum int {BR_NONE, BR_BYTE, BR_FAULT, BR_END} bit_res_t;

  typedef struct {
    logic       cmd;
    logic [7:0] data;
    bit         no_result;
  } dir_row_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  in_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  out_t out_data;

  canonical_huffman_escape_decoder i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  always #5 clk = ~clk;

  // decoder state copy
  logic [31:0] m_window = 0;
  int          m_bits = 0;
  phase_t      m_phase = PH_TYPE;
  logic [15:0] m_type = 0;
  logic [23:0] m_size = 0;
  logic [7:0]  m_esc = 0;
  logic [8:0]  m_cnt[16];
  logic [16:0] m_lim[16];
  logic [15:0] m_off[16];
  logic [7:0]  m_tab[256];
  bit          m_used[256];
  logic [7:0]  m_next = 8'hff;
  int unsigned m_total = 0;
  logic [31:0] m_run = 0;
  logic [7:0]  m_prev = 0, m_s1 = 0, m_s2 = 0;
  logic [23:0] m_emitted = 0;
  logic [31:0] f_acc = 0;
  int          f_left = 16;
  bit          n_stage = 0;
  int          n_zeros = 0, n_width = 0, n_left = 0;
  logic [31:0] n_acc = 0;
  int          len_now = 1;
  logic [31:0] space_used = 0;
  int          longest = 0, sym_index = 0, code_len = 0;
  logic [15:0] code_acc = 0;

  out_t expected_q[$];
  int errors = 0, n_sent = 0, n_checked = 0;
  int cyc = 0;
  bit hold_go = 0;

  // stream builder
  bit          sbits[$];
  logic [7:0]  sbytes[$];
  int          gcnt[9], gfirst[9], gbase[9];
  logic [7:0]  gsym[256];
  int          gcode[256], glen[256];
  logic [31:0] gdelta[256];

  initial begin
    foreach (m_cnt[i]) begin
      m_cnt[i] = 0; m_lim[i] = 0; m_off[i] = 0;
    end
  end

  function automatic void start_field(input int n);
    f_acc = 0;
    f_left = n;
  endfunction

  function automatic bit field_bit(input logic b);
    f_acc = {f_acc[30:0], b};
    if (f_left != 0) f_left--;
    return f_left == 0;
  endfunction

  function automatic bit_res_t num_bit(input logic b, output logic [31:0] val);
    val = 0;
    if (!n_stage) begin
      if (!b) begin
        n_zeros++;
        return (n_zeros >= ZERO_LIMIT) ? BR_FAULT : BR_NONE;
      end
      n_width = n_zeros + 2;
      n_left = n_width;
      n_acc = 0;
      n_stage = 1;
      return BR_NONE;
    end
    n_acc = {n_acc[30:0], b};
    n_left--;
    if (n_left != 0) return BR_NONE;
    val = n_acc + ((n_width < 32) ? (32'd1 << n_width) : 32'd0) - 32'd4;
    n_stage = 0;
    n_zeros = 0;
    return BR_BYTE;
  endfunction

  function automatic logic [7:0] deliver(input logic [7:0] raw);
    logic [7:0] v;
    m_prev = raw;
    v = raw;
    if (m_emitted < m_size) begin
      if (m_type == TYPE_DELTA1) begin
        m_s1 = m_s1 + raw;
        v = m_s1;
      end else if (m_type == TYPE_DELTA2) begin
        m_s1 = m_s1 + raw;
        m_s2 = m_s2 + m_s1;
        v = m_s2;
      end
    end
    if (m_emitted < SIZE_MAX24) m_emitted++;
    return v;
  endfunction

  function automatic bit_res_t take_bit(input logic b, output logic [7:0] sym);
    logic [31:0] v, first, full;
    logic [63:0] top, d;
    logic [7:0] s;
    int i;
    bit_res_t r;
    sym = 0;
    case (m_phase)
      PH_TYPE: begin
        if (field_bit(b)) begin
          m_type = f_acc[15:0] & ~SKIP_FLAG;
          m_phase = f_acc[8] ? PH_SKIP : PH_SIZE;
          start_field(24);
        end
        return BR_NONE;
      end
      PH_SKIP: begin
        if (field_bit(b)) begin
          m_phase = PH_SIZE;
          start_field(24);
        end
        return BR_NONE;
      end
      PH_SIZE: begin
        if (field_bit(b)) begin
          m_size = f_acc[23:0];
          m_phase = PH_ESC;
          start_field(8);
        end
        return BR_NONE;
      end
      PH_ESC: begin
        if (field_bit(b)) begin
          m_esc = f_acc[7:0];
          m_phase = PH_COUNTS;
          len_now = 1;
          space_used = 0;
          m_total = 0;
        end
        return BR_NONE;
      end
      PH_COUNTS: begin
        r = num_bit(b, v);
        if (r != BR_BYTE) return r;
        first = space_used << 1;
        full = 32'd1 << len_now;
        top = 64'(first) + 64'(v);
        if (top > 64'(full) || 64'(m_total) + 64'(v) > 64'd256) return BR_FAULT;
        i = (len_now - 1) & 15;
        m_cnt[i] = v[8:0];
        m_lim[i] = top[16:0];
        m_off[i] = first[15:0] - m_total[15:0];
        m_total += v;
        space_used = top[31:0];
        if (v != 0 && space_used == full) begin
          longest = len_now;
          m_phase = PH_SYMS;
          sym_index = 0;
          return BR_NONE;
        end
        if (len_now >= CODE_LEN) return BR_FAULT;
        len_now++;
        return BR_NONE;
      end
      PH_SYMS: begin
        r = num_bit(b, v);
        if (r != BR_BYTE) return r;
        d = 64'(v) % 64'(256 - sym_index) + 64'd1;
        s = m_next;
        while (d != 0) begin
          s = s + 8'd1;
          if (!m_used[s]) d--;
        end
        m_used[s] = 1;
        m_tab[sym_index & 255] = s;
        m_next = s;
        sym_index++;
        if (sym_index >= m_total) begin
          m_phase = PH_DECODE;
          code_acc = 0;
          code_len = 0;
        end
        return BR_NONE;
      end
      PH_DECODE: begin
        code_acc = {code_acc[14:0], b};
        code_len++;
        i = (code_len - 1) & 15;
        if (m_cnt[i] != 0 && 17'(code_acc) < m_lim[i]) begin
          s = m_tab[8'(code_acc - m_off[i])];
          code_acc = 0;
          code_len = 0;
          if (s == m_esc) begin
            m_phase = PH_ESC_NUM;
            return BR_NONE;
          end
          sym = s;
          return BR_BYTE;
        end
        return (code_len >= longest) ? BR_FAULT : BR_NONE;
      end
      PH_ESC_NUM: begin
        r = num_bit(b, v);
        if (r != BR_BYTE) return r;
        if (v != 0) begin
          m_run = v;
          m_phase = PH_DECODE;
        end else begin
          m_phase = PH_ESC_FLAG;
        end
        return BR_NONE;
      end
      PH_ESC_FLAG: begin
        if (b) return BR_END;
        m_phase = PH_ESC_BYTE;
        start_field(8);
        return BR_NONE;
      end
      PH_ESC_BYTE: begin
        if (field_bit(b)) begin
          m_phase = PH_DECODE;
          sym = f_acc[7:0];
          return BR_BYTE;
        end
        return BR_NONE;
      end
      default: return BR_NONE;
    endcase
  endfunction

  function automatic out_t mk(input logic [7:0] v, input logic [1:0] st);
    out_t r;
    r = '0;
    r.out_byte = v;
    r.status = st;
    r.decoded_size = m_size;
    return r;
  endfunction

  function automatic bit stream_pending();
    return m_phase != PH_END && m_phase != PH_ERROR && (m_run != 0 || m_bits != 0);
  endfunction

  task automatic predict_request(input logic c, input logic [7:0] d, input bit keep);
    out_t res_q[$];
    logic [7:0] sym;
    logic b;
    bit_res_t r;
    int lim;
    bit pend;
    lim = (BURST < MAX_RESULTS) ? BURST : MAX_RESULTS;
    if (m_phase == PH_END) begin
      if (!c) res_q.push_back(mk(0, ST_AFTER_END));
    end else if (m_phase == PH_ERROR) begin
      res_q.push_back(mk(0, ST_MALFORMED));
    end else if (!c && (m_run != 0 || m_bits != 0)) begin
      res_q.push_back(mk(0, ST_PENDING));
    end else begin
      if (!c) begin
        m_window = {d, 24'h0};
        m_bits = 8;
      end
      while (res_q.size() < lim) begin
        if (m_phase == PH_DECODE && m_run != 0) begin
          m_run--;
          res_q.push_back(mk(deliver(m_prev), ST_OK));
          continue;
        end
        if (m_bits == 0) break;
        b = m_window[31];
        m_window = m_window << 1;
        m_bits--;
        r = take_bit(b, sym);
        if (r == BR_BYTE) begin
          res_q.push_back(mk(deliver(sym), ST_OK));
        end else if (r == BR_FAULT) begin
          m_phase = PH_ERROR;
          m_window = 0;
          m_bits = 0;
          m_run = 0;
          res_q.push_back(mk(0, ST_MALFORMED));
          break;
        end else if (r == BR_END) begin
          m_phase = PH_END;
          m_window = 0;
          m_bits = 0;
          if (res_q.size() == 0) res_q.push_back(mk(0, ST_OK));
          break;
        end
      end
    end
    pend = stream_pending();
    foreach (res_q[k]) begin
      res_q[k].last = (k == res_q.size() - 1);
      res_q[k].end_of_stream = (m_phase == PH_END);
      res_q[k].pending = pend;
      if (keep) expected_q.push_back(res_q[k]);
    end
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic send_request(input logic c, input logic [7:0] d, input bit keep);
    int g;
    in_data = '{cmd: c, data_byte: d};
    in_valid = 1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_request(c, d, keep);
    n_sent++;
    @(negedge clk);
    g = gap_len();
    if (g > 0) begin
      in_valid = 0;
      repeat (g) @(negedge clk);
    end
  endtask

  task automatic put_bits(input logic [63:0] v, input int n);
    for (int k = n - 1; k >= 0; k--) sbits.push_back(v[k]);
  endtask

  task automatic put_num(input logic [63:0] n);
    int k;
    k = 0;
    while (n + 64'd4 >= (64'd1 << (k + 3))) k++;
    repeat (k) sbits.push_back(1'b0);
    sbits.push_back(1'b1);
    put_bits(n + 64'd4 - (64'd1 << (k + 2)), k + 2);
  endtask

  task automatic put_code(input int j);
    put_bits(64'(gcode[j]), glen[j]);
  endtask

  // monitor
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc > LIMIT) begin
      $display("canonical_huffman_escape_decoder test failed");
      $finish;
    end
    if (!rst && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result %p", $time, out_data);
        errors++;
      end else begin
        if (out_data !== expected_q[0]) begin
          $display("%0t: mismatch expected %p actual %p", $time, expected_q[0], out_data);
          errors++;
        end
        void'(expected_q.pop_front());
        n_checked++;
      end
    end
  end

  // receiver
  initial begin
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (hold_go) begin
        hold_go = 0;
        out_ready = 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (stall > 0) begin
        out_ready = 0;
        stall--;
      end else begin
        out_ready = 1;
        if ($urandom_range(0, 5) == 0) stall = gap_len();
      end
    end
  end

  initial begin
    dir_row_t rows[$];
    logic [15:0] type_w;
    logic [23:0] size_w;
    logic [63:0] d64;
    logic [7:0] s;
    bit gused[256];
    int maxl, space, room, total, esc_idx, hdr_n, j, r, hold_at, drain_at, events;
    bit use_fault, held, drained;

    // tables: a full canonical tree, depth up to 8
    maxl = ($urandom_range(0, 4) == 0) ? 8 : $urandom_range(1, 5);
    space = 0;
    total = 0;
    for (int len = 1; len <= maxl; len++) begin
      gfirst[len] = space * 2;
      room = (1 << len) - gfirst[len];
      gcnt[len] = (len == maxl) ? room : $urandom_range(0, room - 1);
      gbase[len] = total;
      for (int k = 0; k < gcnt[len]; k++) begin
        gcode[total + k] = gfirst[len] + k;
        glen[total + k] = len;
      end
      total += gcnt[len];
      space = gfirst[len] + gcnt[len];
    end
    s = 8'hff;
    for (int k = 0; k < total; k++) begin
      gdelta[k] = ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, 300);
      d64 = 64'(gdelta[k]) % 64'(256 - k) + 64'd1;
      while (d64 != 0) begin
        s = s + 8'd1;
        if (!gused[s]) d64--;
      end
      gused[s] = 1;
      gsym[k] = s;
    end
    esc_idx = $urandom_range(0, total - 1);

    r = $urandom_range(0, 2);
    type_w = (r == 0) ? TYPE_DELTA1 : (r == 1) ? TYPE_DELTA2 : 16'($urandom);
    type_w[8] = $urandom_range(0, 1);
    r = $urandom_range(0, 5);
    size_w = (r == 0) ? 24'h0 : (r == 1) ? SIZE_MAX24 : 24'($urandom_range(0, 200));
    put_bits(64'(type_w), 16);
    if (type_w[8]) put_bits(64'($urandom), 24);
    put_bits(64'(size_w), 24);
    put_bits(64'(gsym[esc_idx]), 8);
    hdr_n = type_w[8] ? 9 : 6;
    for (int len = 1; len <= maxl; len++) put_num(64'(gcnt[len]));
    for (int k = 0; k < total; k++) put_num(64'(gdelta[k]));

    // body: a run before any byte first
    put_code(esc_idx);
    put_num(64'd3);
    events = 0;
    while ((sbits.size() < 8 * 240 || events < 40) && events < 600) begin
      r = $urandom_range(0, 99);
      events++;
      if (r < 72) begin
        do j = $urandom_range(0, total - 1); while (j == esc_idx);
        put_code(j);
      end else if (r < 86) begin
        put_code(esc_idx);
        put_num(($urandom_range(0, 9) == 0) ? 64'($urandom_range(41, 120))
                                            : 64'($urandom_range(1, 40)));
      end else begin
        put_code(esc_idx);
        put_num(64'd0);
        sbits.push_back(1'b0);
        put_bits(64'($urandom_range(0, 255)), 8);
      end
    end
    use_fault = ($urandom_range(0, 3) == 0);
    put_code(esc_idx);
    if (use_fault) begin
      repeat (32) sbits.push_back(1'b0);
    end else begin
      put_num(64'd0);
      sbits.push_back(1'b1);
    end
    while (sbits.size() % 8 != 0) sbits.push_back(1'($urandom_range(0, 1)));
    for (int k = 0; k < sbits.size(); k += 8) begin
      sbytes.push_back({sbits[k], sbits[k+1], sbits[k+2], sbits[k+3],
                        sbits[k+4], sbits[k+5], sbits[k+6], sbits[k+7]});
    end

    // directed: idle continue, header bytes (no output), idle continue
    rows.push_back('{cmd: 1'b1, data: 8'hff, no_result: 1'b1});
    for (int k = 0; k < hdr_n; k++) rows.push_back('{cmd: 1'b0, data: sbytes[k], no_result: 1'b1});
    rows.push_back('{cmd: 1'b1, data: 8'h00, no_result: 1'b1});

    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    foreach (rows[k]) send_request(rows[k].cmd, rows[k].data, !rows[k].no_result);

    // long receiver hold once the body is being decoded, so results back up
    hold_at = $urandom_range(hdr_n + 20, hdr_n + 80);
    drain_at = hold_at + $urandom_range(20, 60);
    for (int i = hdr_n; i < sbytes.size(); i++) begin
      while (stream_pending()) begin
        if ($urandom_range(0, 19) == 0) send_request(0, 8'($urandom), 1);
        send_request(1, 8'($urandom), 1);
      end
      if ($urandom_range(0, 24) == 0) send_request(1, 8'($urandom), 1);
      if (!held && i >= hold_at && m_phase == PH_DECODE) begin
        hold_go = 1;
        held = 1;
      end
      if (!drained && i >= drain_at) begin
        drained = 1;
        in_valid = 0;
        while (expected_q.size() != 0) @(negedge clk);
      end
      send_request(0, sbytes[i], 1);
      if (m_phase == PH_END || m_phase == PH_ERROR) break;
    end
    repeat (6) send_request(1'($urandom_range(0, 1)), 8'($urandom), 1);
    in_valid = 0;

    while (expected_q.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    $display("sent %0d requests, checked %0d results; type %h, %0d symbols, depth %0d",
             n_sent, n_checked, type_w, total, maxl);
    $display("stream closed by %s", use_fault ? "a malformed escape number" : "the end escape");
    if (errors == 0 && expected_q.size() == 0) begin
      $display("canonical_huffman_escape_decoder test passed");
    end else begin
      $display("canonical_huffman_escape_decoder test failed");
    end
    $finish;
  end

endmodule
